@@ hdl/bic_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and coefficient tables for the scaled Bessel I0 block.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package bic_pkg;

   localparam int LOW_ROM_SIZE        = 30;
   localparam int HIGH_ROM_SIZE       = 25;
   localparam int LOW_TERMS_DEFAULT   = 30;
   localparam int HIGH_TERMS_DEFAULT  = 25;
   localparam int FRAC_BITS_DEFAULT   = 16;

   localparam int IDX_W      = 5;
   localparam int CNT_W      = 7;
   localparam int MUL_STEPS  = 4;
   localparam int DIV_STEPS  = 128;
   localparam int SQRT_STEPS = 32;

   localparam logic signed [63:0] QMAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic [31:0]        OUT_MAX = 32'h8000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_RECIP,
      ST_YSET,
      ST_INIT,
      ST_MUL,
      ST_STEP,
      ST_HALVE,
      ST_SQUARE,
      ST_DIV_START,
      ST_DIV_SQ,
      ST_SQRT_START,
      ST_SQRT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             load_arg;
      logic             div_start;
      logic             div_sel_sq;
      logic             div_step;
      logic             set_y;
      logic             init_b;
      logic             mul_step;
      logic             mul_sq;
      logic             step_b;
      logic             halve;
      logic             sqrt_start;
      logic             sqrt_step;
      logic             load_out;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic high_range;
      logic sum_pos;
   } status_type;

   // Decimal coefficient (mant * 10^-scale) to Q4.60, round half away from zero.
   function automatic logic signed [63:0] rom_q60(input logic [63:0] mant,
                                                  input int scale,
                                                  input logic neg);
      logic [127:0] x;
      logic [63:0]  q;
      x = {64'd0, mant} << 61;
      for (int k = 0; k < scale; k++) begin
         x = x / 128'd10;
      end
      q = (x[63:0] + 64'd1) >> 1;
      return neg ? -$signed(q) : $signed(q);
   endfunction

   localparam logic signed [63:0] LOW_ROM [LOW_ROM_SIZE] = '{
      rom_q60(64'd4415341646479339380, 36, 1'b1), rom_q60(64'd3330794518822238098, 35, 1'b0),
      rom_q60(64'd2431279846547954694, 34, 1'b1), rom_q60(64'd1715391285555133031, 33, 1'b0),
      rom_q60(64'd1168533287799345168, 32, 1'b1), rom_q60(64'd7676185498604935617, 32, 1'b0),
      rom_q60(64'd4856446783111929461, 31, 1'b1), rom_q60(64'd2955052663129639835, 30, 1'b0),
      rom_q60(64'd1726826291441555707, 29, 1'b1), rom_q60(64'd9675809035373236912, 29, 1'b0),
      rom_q60(64'd5189795601635262907, 28, 1'b1), rom_q60(64'd2659823724682386650, 27, 1'b0),
      rom_q60(64'd1300025009986248042, 26, 1'b1), rom_q60(64'd6046995022541918949, 26, 1'b0),
      rom_q60(64'd2670793853940611734, 25, 1'b1), rom_q60(64'd1117387539120103718, 24, 1'b0),
      rom_q60(64'd4416738358458750564, 24, 1'b1), rom_q60(64'd1644844807072889709, 23, 1'b0),
      rom_q60(64'd5754195010082103704, 23, 1'b1), rom_q60(64'd1885028850958416557, 22, 1'b0),
      rom_q60(64'd5763755745385823659, 22, 1'b1), rom_q60(64'd1639475616941335798, 21, 1'b0),
      rom_q60(64'd4324309995050575944, 21, 1'b1), rom_q60(64'd1054646039459499832, 20, 1'b0),
      rom_q60(64'd2373741480589946882, 20, 1'b1), rom_q60(64'd4930528423967070849, 20, 1'b0),
      rom_q60(64'd9490109704804764442, 20, 1'b1), rom_q60(64'd1716209015222087753, 19, 1'b0),
      rom_q60(64'd3046826723431983987, 19, 1'b1), rom_q60(64'd6767952744094760850, 19, 1'b0)
   };

   localparam logic signed [63:0] HIGH_ROM [HIGH_ROM_SIZE] = '{
      rom_q60(64'd7233180487874753955, 36, 1'b1), rom_q60(64'd4830504485944182071, 36, 1'b1),
      rom_q60(64'd4465621420296759999, 35, 1'b0), rom_q60(64'd3461222867697461093, 35, 1'b0),
      rom_q60(64'd2827623980516583485, 34, 1'b1), rom_q60(64'd3425485619677219135, 34, 1'b1),
      rom_q60(64'd1772560133056526384, 33, 1'b0), rom_q60(64'd3811680669352622421, 33, 1'b0),
      rom_q60(64'd9554846698828307649, 33, 1'b1), rom_q60(64'd4150569347287222087, 32, 1'b1),
      rom_q60(64'd1540086217521409827, 32, 1'b0), rom_q60(64'd3852778382742142701, 31, 1'b0),
      rom_q60(64'd7180124451383666234, 31, 1'b0), rom_q60(64'd1794178531506806118, 30, 1'b1),
      rom_q60(64'd1321581184044771312, 29, 1'b1), rom_q60(64'd3149916527963241365, 29, 1'b1),
      rom_q60(64'd1188914710784643834, 29, 1'b0), rom_q60(64'd4940602388224969589, 28, 1'b0),
      rom_q60(64'd3396232025708386345, 27, 1'b0), rom_q60(64'd2266668990498178065, 26, 1'b0),
      rom_q60(64'd2048918589469063742, 25, 1'b0), rom_q60(64'd2891370520834756483, 24, 1'b0),
      rom_q60(64'd6889758346916823984, 23, 1'b0), rom_q60(64'd3369116478255694090, 21, 1'b0),
      rom_q60(64'd8044904110141088316, 19, 1'b0)
   };

   function automatic logic signed [63:0] coef(input logic high, input logic [IDX_W-1:0] idx);
      logic signed [63:0] c;
      c = '0;
      if (high) begin
         if (idx < IDX_W'(HIGH_ROM_SIZE)) begin
            c = HIGH_ROM[idx];
         end
      end else begin
         if (idx < IDX_W'(LOW_ROM_SIZE)) begin
            c = LOW_ROM[idx];
         end
      end
      return c;
   endfunction

   // Saturating Q4.60 add, clamps to +-QMAX.
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(QMAX)) begin
         return QMAX;
      end else if (s < -65'(QMAX)) begin
         return -QMAX;
      end
      return $signed(s[63:0]);
   endfunction

endpackage

@@ hdl/bic_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the scaled Bessel I0 block: handshakes, step counters, ROM index.
// Depends on bic_pkg for the state, command and status types.
module bic_ctrl #(
   parameter int LOW_RANGE_TERMS  = bic_pkg::LOW_TERMS_DEFAULT,
   parameter int HIGH_RANGE_TERMS = bic_pkg::HIGH_TERMS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  bic_pkg::status_type  status,
   output bic_pkg::cmd_type     cmd
);

   localparam logic [bic_pkg::IDX_W-1:0] FIRST_LOW =
      bic_pkg::IDX_W'(bic_pkg::LOW_ROM_SIZE - LOW_RANGE_TERMS);
   localparam logic [bic_pkg::IDX_W-1:0] FIRST_HIGH =
      bic_pkg::IDX_W'(bic_pkg::HIGH_ROM_SIZE - HIGH_RANGE_TERMS);
   localparam logic [bic_pkg::IDX_W-1:0] LAST_LOW  = bic_pkg::IDX_W'(bic_pkg::LOW_ROM_SIZE - 1);
   localparam logic [bic_pkg::IDX_W-1:0] LAST_HIGH = bic_pkg::IDX_W'(bic_pkg::HIGH_ROM_SIZE - 1);

   bic_pkg::state_type state_ff, state_in;
   logic [bic_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [bic_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bic_pkg::ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.idx      = idx_ff;
      cmd.cnt      = cnt_ff;
      req_stall    = (state_ff != bic_pkg::ST_IDLE);
      case (state_ff)
         bic_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_arg = 1'b1;
               state_in     = bic_pkg::ST_PREP;
            end
         end
         bic_pkg::ST_PREP: begin
            if (status.high_range) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = bic_pkg::ST_DIV_RECIP;
            end else begin
               state_in = bic_pkg::ST_YSET;
            end
         end
         bic_pkg::ST_DIV_RECIP: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == bic_pkg::CNT_W'(bic_pkg::DIV_STEPS - 1)) begin
               state_in = bic_pkg::ST_YSET;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bic_pkg::ST_YSET: begin
            cmd.set_y = 1'b1;
            idx_in    = status.high_range ? FIRST_HIGH : FIRST_LOW;
            state_in  = bic_pkg::ST_INIT;
         end
         bic_pkg::ST_INIT: begin
            cmd.init_b = 1'b1;
            idx_in     = idx_ff + 1'b1;
            cnt_in     = '0;
            state_in   = bic_pkg::ST_MUL;
         end
         bic_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == bic_pkg::CNT_W'(bic_pkg::MUL_STEPS)) begin
               state_in = bic_pkg::ST_STEP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bic_pkg::ST_STEP: begin
            cmd.step_b = 1'b1;
            if (idx_ff == (status.high_range ? LAST_HIGH : LAST_LOW)) begin
               state_in = bic_pkg::ST_HALVE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               cnt_in   = '0;
               state_in = bic_pkg::ST_MUL;
            end
         end
         bic_pkg::ST_HALVE: begin
            cmd.halve = 1'b1;
            cnt_in    = '0;
            if (status.high_range && status.sum_pos) begin
               state_in = bic_pkg::ST_SQUARE;
            end else begin
               state_in = bic_pkg::ST_OUT;
            end
         end
         bic_pkg::ST_SQUARE: begin
            cmd.mul_step = 1'b1;
            cmd.mul_sq   = 1'b1;
            if (cnt_ff == bic_pkg::CNT_W'(bic_pkg::MUL_STEPS)) begin
               state_in = bic_pkg::ST_DIV_START;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bic_pkg::ST_DIV_START: begin
            cmd.div_start  = 1'b1;
            cmd.div_sel_sq = 1'b1;
            cnt_in         = '0;
            state_in       = bic_pkg::ST_DIV_SQ;
         end
         bic_pkg::ST_DIV_SQ: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == bic_pkg::CNT_W'(bic_pkg::DIV_STEPS - 1)) begin
               state_in = bic_pkg::ST_SQRT_START;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bic_pkg::ST_SQRT_START: begin
            cmd.sqrt_start = 1'b1;
            cnt_in         = '0;
            state_in       = bic_pkg::ST_SQRT;
         end
         bic_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == bic_pkg::CNT_W'(bic_pkg::SQRT_STEPS - 1)) begin
               state_in = bic_pkg::ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         bic_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = bic_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bic_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/bic_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: argument magnitude, Clenshaw registers, 32x32 partial-product multiplier,
// restoring divider, bit-pair square root and output register. Uses bic_pkg.
module bic_datapath #(
   parameter int ARG_FRAC_BITS = bic_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic signed [31:0]  arg_value,
   input  bic_pkg::cmd_type    cmd,
   output bic_pkg::status_type status,
   output logic [31:0]         result
);

   localparam int Y_SHIFT   = 59 - ARG_FRAC_BITS;
   localparam int RECIP_BIT = 65 + ARG_FRAC_BITS;
   localparam int SQ_SHIFT  = 58 - ARG_FRAC_BITS;
   localparam logic [31:0] LOW_LIMIT = 32'd8 << ARG_FRAC_BITS;
   localparam logic signed [63:0] Y_OFFSET  = 64'sh2000_0000_0000_0000;
   localparam logic [127:0]       ROUND_BIT = 128'd1 << 59;

   logic [31:0]        mag_ff;
   logic               high_ff;
   logic signed [63:0] y_ff, b0_ff, b1_ff, b2_ff, s_ff;
   logic [63:0]        pp_ff;
   logic [1:0]         pp_sh_ff;
   logic [127:0]       acc_ff, num_ff, quo_ff;
   logic [32:0]        rem_ff;
   logic [63:0]        sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [31:0]        out_ff;

   logic [31:0]        mag_in;
   logic signed [63:0] op_a, op_b;
   logic [63:0]        mag_a, mag_b;
   logic [31:0]        pa, pb;
   logic [1:0]         psh;
   logic [127:0]       pp_shifted, rounded;
   logic signed [63:0] prod_mag, prod, b0_in;
   logic signed [63:0] d, dmag, h, s_in;
   logic [32:0]        rem_shift;
   logic               qbit, round_up;
   logic [63:0]        trial;
   logic [63:0]        low_r;
   logic [31:0]        low_res, high_res, final_res;

   assign mag_in = arg_value[31] ? 32'(-arg_value) : 32'(arg_value);

   // multiplier operands and partial product selection
   always_comb begin
      op_a  = cmd.mul_sq ? s_ff : y_ff;
      op_b  = cmd.mul_sq ? s_ff : b0_ff;
      mag_a = op_a[63] ? 64'(-op_a) : 64'(op_a);
      mag_b = op_b[63] ? 64'(-op_b) : 64'(op_b);
      case (cmd.cnt[1:0])
         2'd0: begin pa = mag_a[31:0];  pb = mag_b[31:0];  psh = 2'd0; end
         2'd1: begin pa = mag_a[31:0];  pb = mag_b[63:32]; psh = 2'd1; end
         2'd2: begin pa = mag_a[63:32]; pb = mag_b[31:0];  psh = 2'd1; end
         2'd3: begin pa = mag_a[63:32]; pb = mag_b[63:32]; psh = 2'd2; end
         default: begin pa = '0; pb = '0; psh = 2'd0; end
      endcase
      case (pp_sh_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd1:    pp_shifted = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_shifted = {pp_ff, 64'd0};
         default: pp_shifted = '0;
      endcase
   end

   // round the product to Q4.60, saturate, then the Clenshaw update
   always_comb begin
      rounded  = acc_ff + ROUND_BIT;
      prod_mag = (|rounded[127:123]) ? bic_pkg::QMAX : $signed({1'b0, rounded[122:60]});
      prod     = (y_ff[63] ^ b0_ff[63]) ? -prod_mag : prod_mag;
      b0_in    = bic_pkg::sat_add(bic_pkg::sat_add(prod, -b1_ff),
                                  bic_pkg::coef(high_ff, cmd.idx));
      d        = bic_pkg::sat_add(b0_ff, -b2_ff);
      dmag     = d[63] ? -d : d;
      h        = $signed(($unsigned(dmag) + 64'd1) >> 1);
      s_in     = d[63] ? -h : h;
   end

   always_comb begin
      rem_shift = {rem_ff[31:0], num_ff[127]};
      qbit      = (rem_shift >= {1'b0, mag_ff});
      round_up  = ({rem_ff, 1'b0} >= {2'b00, mag_ff});
      trial     = sq_res_ff + sq_bit_ff;
   end

   // final result selection
   always_comb begin
      low_r   = 64'(s_ff + 64'sd268435456) >> 29;
      low_res = (low_r > 64'(bic_pkg::OUT_MAX)) ? bic_pkg::OUT_MAX : low_r[31:0];
      if (|quo_ff[127:64]) begin
         high_res = bic_pkg::OUT_MAX;
      end else if (sq_res_ff > 64'(bic_pkg::OUT_MAX)) begin
         high_res = bic_pkg::OUT_MAX;
      end else begin
         high_res = sq_res_ff[31:0];
      end
      if (s_ff[63] || (s_ff == 64'sd0)) begin
         final_res = '0;
      end else begin
         final_res = high_ff ? high_res : low_res;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_arg) begin
         mag_ff  <= mag_in;
         high_ff <= (mag_in > LOW_LIMIT);
      end
      if (cmd.set_y) begin
         if (high_ff) begin
            y_ff <= $signed(quo_ff[63:0] + 64'(round_up)) - Y_OFFSET;
         end else begin
            y_ff <= $signed({32'd0, mag_ff} << Y_SHIFT) - Y_OFFSET;
         end
      end
      if (cmd.init_b) begin
         b0_ff <= bic_pkg::coef(high_ff, cmd.idx);
         b1_ff <= '0;
         b2_ff <= '0;
      end else if (cmd.step_b) begin
         b2_ff <= b1_ff;
         b1_ff <= b0_ff;
         b0_ff <= b0_in;
      end
      if (cmd.halve) begin
         s_ff <= s_in;
      end
      if (cmd.mul_step) begin
         pp_ff    <= pa * pb;
         pp_sh_ff <= psh;
         if (cmd.cnt == '0) begin
            acc_ff <= '0;
         end else begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
      if (cmd.div_start) begin
         num_ff <= cmd.div_sel_sq ? (acc_ff >> SQ_SHIFT) : (128'd1 << RECIP_BIT);
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         rem_ff <= qbit ? (rem_shift - {1'b0, mag_ff}) : rem_shift;
         quo_ff <= {quo_ff[126:0], qbit};
      end
      if (cmd.sqrt_start) begin
         sq_v_ff   <= quo_ff[63:0];
         sq_res_ff <= '0;
         sq_bit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (sq_v_ff >= trial) begin
            sq_v_ff   <= sq_v_ff - trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.load_out) begin
         out_ff <= final_res;
      end
   end

   assign status.high_range = high_ff;
   assign status.sum_pos    = !d[63] && (d != 64'sd0);
   assign result            = out_ff;

endmodule

@@ hdl/bessel_i0_scaled_chebyshev_top.sv @@
`timescale 1ns / 1ps
// Top level of the exponentially scaled Bessel I0 unit (I0e, Q16.16 in, Q1.31 out).
// Depends on bic_pkg, bic_ctrl and bic_datapath.
//
// Usage:
//   Request channel: req_valid / req_stall carry one beat, req_arg_value (signed fixed
//   point, ARG_FRAC_BITS fraction bits). A beat is taken when req_valid is high and
//   req_stall is low. Response channel: rsp_valid / rsp_stall carry rsp_scaled_bessel,
//   exp(-|x|)*I0(x) as unsigned Q1.31 (value / 2^31), never above 2^31.
//   One item at a time. req_stall stays high from acceptance until the result is
//   placed in the output register, then drops for the next beat.
//   The work runs on the shared 32x32 multiplier, one product at a time and one
//   Clenshaw term after another, and on the one-bit-per-cycle divider:
//     |x| <= 8 : LOW_RANGE_TERMS Clenshaw terms only
//     |x| >  8 : a reciprocal divide, HIGH_RANGE_TERMS Clenshaw terms, then a square,
//                a second divide and a square root; these last three are skipped if
//                the sum is not positive. The next beat can be taken in the same cycle that rsp_valid rises.
//   A held output register parts the channels: a stalled result holds its value
//   while the next request is accepted and computed; the unit then waits for the
//   register to drain before loading the new result.
//   Reset (synchronous, active high) returns the sequencer to idle and drops
//   rsp_valid; no clearing pass is needed.
module bessel_i0_scaled_chebyshev_top #(
   parameter int LOW_RANGE_TERMS  = bic_pkg::LOW_TERMS_DEFAULT,
   parameter int HIGH_RANGE_TERMS = bic_pkg::HIGH_TERMS_DEFAULT,
   parameter int ARG_FRAC_BITS    = bic_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_arg_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [31:0]        rsp_scaled_bessel
);

   bic_pkg::cmd_type    cmd;
   bic_pkg::status_type status;

   // sequencer: owns both handshakes and every step count
   bic_ctrl #(
      .LOW_RANGE_TERMS  (LOW_RANGE_TERMS),
      .HIGH_RANGE_TERMS (HIGH_RANGE_TERMS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic: range select, recurrence, divide, square root, output register
   bic_datapath #(
      .ARG_FRAC_BITS (ARG_FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .arg_value (req_arg_value),
      .cmd       (cmd),
      .status    (status),
      .result    (rsp_scaled_bessel)
   );

   // result never exceeds one in Q1.31
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_scaled_bessel <= bic_pkg::OUT_MAX))
      else $error("result above saturation limit");

   // an accepted beat keeps the unit busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted back to back");

   // a new result only appears after the unit was busy computing it
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");

endmodule
